FILE: rtl/lcdfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfr_pkg
// Shared types and constants for the display window and pixel framer.
// ----------------------------------------------------------------------------
package lcdfr_pkg;

    // request mode
    typedef enum logic {
        MODE_WINDOW = 1'b0,
        MODE_PIXEL  = 1'b1
    } t_mode;

    // configuration register indexes
    localparam logic [1:0] CFG_PANEL_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_PANEL_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_COLUMN_OFFSET = 2'd2;
    localparam logic [1:0] CFG_ROW_OFFSET    = 2'd3;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam int SIZE_W     = 11;
    localparam int OFFS_W     = 10;
    localparam int COORD_W    = 16;

    // reset values of the registers
    localparam logic [SIZE_W-1:0] PANEL_SIZE_RST = 11'd240;

    // controller commands
    localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET    = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;

    // request queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // classified request after the first front stage
    typedef struct packed {
        t_mode              mode;
        logic               start_ok;
        logic [COORD_W-1:0] col0;
        logic [COORD_W-1:0] col1;
        logic [COORD_W-1:0] row0;
        logic [COORD_W-1:0] row1;
        logic [15:0]        pixel;
        logic               burst_end;
    } t_pre;

    // request ready to be sent, as held in the queue
    typedef struct packed {
        t_mode              mode;
        logic [COORD_W-1:0] col0;
        logic [COORD_W-1:0] col1;
        logic [COORD_W-1:0] row0;
        logic [COORD_W-1:0] row1;
        logic [15:0]        pixel;
        logic               burst_end;
    } t_cmd;

    // queue status seen by the front
    typedef struct packed {
        logic full;
    } t_q_wstat;

    // queue head status seen by the back
    typedef struct packed {
        logic valid;
    } t_q_rstat;

endpackage

FILE: rtl/lcd_window_and_pixel_command_framer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_window_and_pixel_command_framer_core
// Display request framer: window and pixel requests in, tagged bus words out.
// ----------------------------------------------------------------------------
// a request's first word passes the front stage register, the queue and the output word register
//   before it shows on the result ports; a pixel is two words and a window eleven, emitted by
//   the back end one word a cycle while words are popped; a rejected window leaves with no word
// a request may be pushed every cycle while the 2-entry queue has room
// reset: synchronous, active low; clears front stage, queue and output word valid, loads register
//   reset values (panel 240 x 240, zero offsets)
module lcd_window_and_pixel_command_framer_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [lcdfr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lcdfr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // requests
    input  logic                             push,
    output logic                             full,
    input  logic                             i_mode,
    input  logic [15:0]                      i_start_col,
    input  logic [15:0]                      i_start_row,
    input  logic [15:0]                      i_end_col,
    input  logic [15:0]                      i_end_row,
    input  logic [15:0]                      i_pixel,
    input  logic                             i_burst_end,
    // bus words
    output logic                             empty,
    input  logic                             pop,
    output logic [7:0]                       o_bus_byte,
    output logic                             o_is_data,
    output logic                             o_release_select,
    output logic                             o_last
);

    logic                w_q_wr;
    lcdfr_pkg::t_cmd     w_q_wdata;
    lcdfr_pkg::t_q_wstat w_q_wstat;
    logic                w_q_rd;
    lcdfr_pkg::t_cmd     w_q_head;
    lcdfr_pkg::t_q_rstat w_q_rstat;

    // request checking and offsets
    lcdfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .o_full      (full),
        .i_mode      (i_mode),
        .i_start_col (i_start_col),
        .i_start_row (i_start_row),
        .i_end_col   (i_end_col),
        .i_end_row   (i_end_row),
        .i_pixel     (i_pixel),
        .i_burst_end (i_burst_end),
        .o_q_wr      (w_q_wr),
        .o_q_wdata   (w_q_wdata),
        .i_q_wstat   (w_q_wstat)
    );

    // request queue
    lcdfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_wdata (w_q_wdata),
        .o_wstat (w_q_wstat),
        .i_rd    (w_q_rd),
        .o_rdata (w_q_head),
        .o_rstat (w_q_rstat)
    );

    // word sequencer
    lcdfr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (w_q_head),
        .i_q_rstat        (w_q_rstat),
        .o_q_rd           (w_q_rd),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_bus_byte       (o_bus_byte),
        .o_is_data        (o_is_data),
        .o_release_select (o_release_select),
        .o_last           (o_last)
    );

endmodule

FILE: rtl/lcdfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfr_front
// Accepts requests, holds the configuration, checks and clamps windows and
// adds the memory offsets before handing requests to the queue.
// ----------------------------------------------------------------------------
module lcdfr_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [lcdfr_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [lcdfr_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // request side
    input  logic                              i_push,
    output logic                              o_full,
    input  logic                              i_mode,
    input  logic [15:0]                       i_start_col,
    input  logic [15:0]                       i_start_row,
    input  logic [15:0]                       i_end_col,
    input  logic [15:0]                       i_end_row,
    input  logic [15:0]                       i_pixel,
    input  logic                              i_burst_end,
    // queue write side
    output logic                              o_q_wr,
    output lcdfr_pkg::t_cmd                   o_q_wdata,
    input  lcdfr_pkg::t_q_wstat               i_q_wstat
);

    logic [lcdfr_pkg::SIZE_W-1:0] r_panel_width;
    logic [lcdfr_pkg::SIZE_W-1:0] r_panel_height;
    logic [lcdfr_pkg::OFFS_W-1:0] r_column_offset;
    logic [lcdfr_pkg::OFFS_W-1:0] r_row_offset;

    lcdfr_pkg::t_pre r_pre;
    lcdfr_pkg::t_pre n_pre;
    logic            r_pv;

    logic [lcdfr_pkg::COORD_W-1:0] w_width_ext;
    logic [lcdfr_pkg::COORD_W-1:0] w_height_ext;
    logic                          w_accept;
    logic                          w_drop;
    logic                          w_leave;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_width   <= lcdfr_pkg::PANEL_SIZE_RST;
            r_panel_height  <= lcdfr_pkg::PANEL_SIZE_RST;
            r_column_offset <= '0;
            r_row_offset    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                lcdfr_pkg::CFG_PANEL_WIDTH:   r_panel_width   <= i_cfg_wdata;
                lcdfr_pkg::CFG_PANEL_HEIGHT:  r_panel_height  <= i_cfg_wdata;
                lcdfr_pkg::CFG_COLUMN_OFFSET:
                    r_column_offset <= i_cfg_wdata[lcdfr_pkg::OFFS_W-1:0];
                lcdfr_pkg::CFG_ROW_OFFSET:
                    r_row_offset <= i_cfg_wdata[lcdfr_pkg::OFFS_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_width_ext  = {{(lcdfr_pkg::COORD_W-lcdfr_pkg::SIZE_W){1'b0}}, r_panel_width};
    assign w_height_ext = {{(lcdfr_pkg::COORD_W-lcdfr_pkg::SIZE_W){1'b0}}, r_panel_height};

    // first stage: start corner check and end clamp
    always_comb begin
        n_pre.mode      = lcdfr_pkg::t_mode'(i_mode);
        n_pre.start_ok  = (i_start_col < w_width_ext) && (i_start_row < w_height_ext);
        n_pre.col0      = i_start_col;
        n_pre.row0      = i_start_row;
        n_pre.col1      = (i_end_col >= w_width_ext) ? (w_width_ext - 16'd1) : i_end_col;
        n_pre.row1      = (i_end_row >= w_height_ext) ? (w_height_ext - 16'd1) : i_end_row;
        n_pre.pixel     = i_pixel;
        n_pre.burst_end = i_burst_end;
    end

    // second stage: inverted window check and offsets
    assign w_drop = (r_pre.mode == lcdfr_pkg::MODE_WINDOW) &&
                    (!r_pre.start_ok || (r_pre.col1 < r_pre.col0) ||
                     (r_pre.row1 < r_pre.row0));
    assign o_q_wr  = r_pv && !w_drop && !i_q_wstat.full;
    assign w_leave = r_pv && (w_drop || !i_q_wstat.full);
    assign o_full  = r_pv && !w_leave;
    assign w_accept = i_push && !o_full;

    always_comb begin
        o_q_wdata.mode      = r_pre.mode;
        o_q_wdata.col0      = r_pre.col0 +
                              {{(lcdfr_pkg::COORD_W-lcdfr_pkg::OFFS_W){1'b0}}, r_column_offset};
        o_q_wdata.col1      = r_pre.col1 +
                              {{(lcdfr_pkg::COORD_W-lcdfr_pkg::OFFS_W){1'b0}}, r_column_offset};
        o_q_wdata.row0      = r_pre.row0 +
                              {{(lcdfr_pkg::COORD_W-lcdfr_pkg::OFFS_W){1'b0}}, r_row_offset};
        o_q_wdata.row1      = r_pre.row1 +
                              {{(lcdfr_pkg::COORD_W-lcdfr_pkg::OFFS_W){1'b0}}, r_row_offset};
        o_q_wdata.pixel     = r_pre.pixel;
        o_q_wdata.burst_end = r_pre.burst_end;
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_accept) begin
            r_pv <= 1'b1;
        end else if (w_leave) begin
            r_pv <= 1'b0;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pre <= n_pre;
        end
    end

endmodule

FILE: rtl/lcdfr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfr_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module lcdfr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  lcdfr_pkg::t_cmd     i_wdata,
    output lcdfr_pkg::t_q_wstat o_wstat,
    input  logic                i_rd,
    output lcdfr_pkg::t_cmd     o_rdata,
    output lcdfr_pkg::t_q_rstat o_rstat
);

    lcdfr_pkg::t_cmd               r_mem [lcdfr_pkg::QDEPTH];
    logic [lcdfr_pkg::QPTR_W-1:0]  r_wp;
    logic [lcdfr_pkg::QPTR_W-1:0]  r_rp;
    logic [lcdfr_pkg::QCNT_W-1:0]  r_cnt;
    logic                          w_wr;
    logic                          w_rd;

    assign w_wr = i_wr && (r_cnt != lcdfr_pkg::QCNT_W'(lcdfr_pkg::QDEPTH));
    assign w_rd = i_rd && (r_cnt != '0);

    assign o_wstat.full  = (r_cnt == lcdfr_pkg::QCNT_W'(lcdfr_pkg::QDEPTH));
    assign o_rstat.valid = (r_cnt != '0);
    assign o_rdata       = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == lcdfr_pkg::QPTR_W'(lcdfr_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == lcdfr_pkg::QPTR_W'(lcdfr_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/lcdfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfr_back
// Walks the queue head byte by byte into the output word register.
// ----------------------------------------------------------------------------
module lcdfr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // queue read side
    input  lcdfr_pkg::t_cmd     i_head,
    input  lcdfr_pkg::t_q_rstat i_q_rstat,
    output logic                o_q_rd,
    // result side
    output logic                o_empty,
    input  logic                i_pop,
    output logic [7:0]          o_bus_byte,
    output logic                o_is_data,
    output logic                o_release_select,
    output logic                o_last
);

    localparam int IDX_W = 4;

    // byte positions of the window sequence
    localparam logic [IDX_W-1:0] IDX_COL_CMD = 4'd0;
    localparam logic [IDX_W-1:0] IDX_COL0_HI = 4'd1;
    localparam logic [IDX_W-1:0] IDX_COL0_LO = 4'd2;
    localparam logic [IDX_W-1:0] IDX_COL1_HI = 4'd3;
    localparam logic [IDX_W-1:0] IDX_COL1_LO = 4'd4;
    localparam logic [IDX_W-1:0] IDX_ROW_CMD = 4'd5;
    localparam logic [IDX_W-1:0] IDX_ROW0_HI = 4'd6;
    localparam logic [IDX_W-1:0] IDX_ROW0_LO = 4'd7;
    localparam logic [IDX_W-1:0] IDX_ROW1_HI = 4'd8;
    localparam logic [IDX_W-1:0] IDX_ROW1_LO = 4'd9;
    localparam logic [IDX_W-1:0] IDX_MEM_CMD = 4'd10;
    // byte positions of a pixel
    localparam logic [IDX_W-1:0] IDX_PIX_HI  = 4'd0;
    localparam logic [IDX_W-1:0] IDX_PIX_LO  = 4'd1;

    logic [IDX_W-1:0] r_idx;
    logic             r_ov;
    logic [7:0]       r_byte;
    logic             r_data;
    logic             r_rel;
    logic             r_last;

    logic [7:0]       w_byte;
    logic             w_data;
    logic             w_rel;
    logic             w_last;
    logic             w_load;

    // byte select for the current position
    always_comb begin
        w_byte = 8'h00;
        w_data = 1'b1;
        w_rel  = 1'b1;
        w_last = 1'b0;
        if (i_head.mode == lcdfr_pkg::MODE_PIXEL) begin
            if (r_idx == IDX_PIX_HI) begin
                w_byte = i_head.pixel[15:8];
                w_rel  = 1'b0;
            end
            if (r_idx == IDX_PIX_LO) begin
                w_byte = i_head.pixel[7:0];
                w_rel  = i_head.burst_end;
                w_last = 1'b1;
            end
        end else begin
            unique case (r_idx)
                IDX_COL_CMD: begin
                    w_byte = lcdfr_pkg::CMD_COLUMN_SET;
                    w_data = 1'b0;
                end
                IDX_COL0_HI: w_byte = i_head.col0[15:8];
                IDX_COL0_LO: w_byte = i_head.col0[7:0];
                IDX_COL1_HI: w_byte = i_head.col1[15:8];
                IDX_COL1_LO: w_byte = i_head.col1[7:0];
                IDX_ROW_CMD: begin
                    w_byte = lcdfr_pkg::CMD_ROW_SET;
                    w_data = 1'b0;
                end
                IDX_ROW0_HI: w_byte = i_head.row0[15:8];
                IDX_ROW0_LO: w_byte = i_head.row0[7:0];
                IDX_ROW1_HI: w_byte = i_head.row1[15:8];
                IDX_ROW1_LO: w_byte = i_head.row1[7:0];
                IDX_MEM_CMD: begin
                    w_byte = lcdfr_pkg::CMD_MEM_WRITE;
                    w_data = 1'b0;
                    w_last = 1'b1;
                end
                default: begin
                    w_byte = 8'h00;
                end
            endcase
        end
    end

    assign w_load  = i_q_rstat.valid && (!r_ov || i_pop);
    assign o_q_rd  = w_load && w_last;
    assign o_empty = !r_ov;

    // position counter and output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx <= w_last ? '0 : r_idx + 1'b1;
                r_ov  <= 1'b1;
            end else if (i_pop) begin
                r_ov  <= 1'b0;
            end
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_byte;
            r_data <= w_data;
            r_rel  <= w_rel;
            r_last <= w_last;
        end
    end

    assign o_bus_byte       = r_byte;
    assign o_is_data        = r_data;
    assign o_release_select = r_rel;
    assign o_last           = r_last;

endmodule

FILE: rtl/lcdfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfr_checker
// Port-level checks on the framer's bus word stream.
// ----------------------------------------------------------------------------
module lcdfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_bus_byte,
    input logic       o_is_data,
    input logic       o_release_select,
    input logic       o_last
);

    // nothing to show right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("word shown right after reset");

    // a waiting word holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_bus_byte) && $stable(o_is_data) &&
                              $stable(o_release_select) && $stable(o_last)))
        else $error("waiting word changed");

    // commands always release select, and only memory-write closes a window
    a_cmd_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_is_data) |->
            (o_release_select && (o_last == (o_bus_byte == lcdfr_pkg::CMD_MEM_WRITE))))
        else $error("command word framing wrong");

    // a popped pixel high byte is followed straight away by its low byte
    a_pix_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_is_data && !o_release_select && !o_last) |=>
            (!empty && o_is_data && o_last))
        else $error("pixel low byte not next after high byte");

endmodule

bind lcd_window_and_pixel_command_framer_core lcdfr_checker u_lcdfr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .empty            (empty),
    .pop              (pop),
    .o_bus_byte       (o_bus_byte),
    .o_is_data        (o_is_data),
    .o_release_select (o_release_select),
    .o_last           (o_last)
);
